// ===== sv/text_console_bitplane_writer_defines.svh =====
// Assertion macros for the text console bitplane writer.
// Used by files that carry concurrent checks; clk and rst must be in scope.
`ifndef TEXT_CONSOLE_BITPLANE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_BITPLANE_WRITER_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled during reset
`define TCBW_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, disabled during reset
`define TCBW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define TCBW_ASSERT_SAME(label, ante, cons, msg)
`define TCBW_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== sv/tcbw_pkg.sv =====
// Shared types, constants and helper functions for the text console writer.
// No dependencies; imported by the sequencer and the top level.
package tcbw_pkg;

  // Geometry of the framebuffer, text grid and glyph store
  localparam int FRAME_BYTES = 16640;
  localparam int LINE_BYTES  = 80;
  localparam int TEXT_ROWS   = 25;
  localparam int GLYPH_BYTES = 1792;
  localparam int PAUSE_EVERY = 25;
  localparam int TALLY_RESET = 24;
  localparam int GLYPH_LINES = 8;

  localparam int FRAME_AW = $clog2(FRAME_BYTES);
  localparam int GLYPH_AW = $clog2(GLYPH_BYTES);
  localparam int COL_W    = 7;
  localparam int ROW_W    = 5;
  localparam int TALLY_W  = 5;
  localparam int STEP_W   = $clog2(GLYPH_LINES);

  // One text row is eight pixel lines
  localparam int CELL_SHIFT   = GLYPH_LINES * LINE_BYTES;
  localparam int SCROLL_COUNT = (TEXT_ROWS * CELL_SHIFT < FRAME_BYTES - CELL_SHIFT) ?
                                TEXT_ROWS * CELL_SHIFT : FRAME_BYTES - CELL_SHIFT;

  // Request codes
  localparam logic [1:0] REQ_PUT   = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_CLICK = 2'd2;
  localparam logic [1:0] REQ_GLYPH = 2'd3;

  // Character codes
  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [7:0] CHAR_FIRST   = 8'd32;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  char_code;
    logic [14:0] address;
    logic [7:0]  write_data;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       read_data;
    logic [COL_W-1:0] cursor_col;
    logic [ROW_W-1:0] cursor_row;
    logic             paused;
    logic             rejected;
  } out_item_t;

  // Frame memory access from the sequencer
  typedef struct packed {
    logic                we;
    logic [FRAME_AW-1:0] waddr;
    logic [7:0]          wdata;
    logic                re;
    logic [FRAME_AW-1:0] raddr;
  } frame_port_t;

  // Glyph memory access from the sequencer
  typedef struct packed {
    logic                we;
    logic [GLYPH_AW-1:0] waddr;
    logic [7:0]          wdata;
    logic                re;
    logic [GLYPH_AW-1:0] raddr;
  } glyph_port_t;

  // Cursor state after a put-character
  typedef struct packed {
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
    logic [TALLY_W-1:0] tally;
    logic               pause;
    logic               scroll;
  } cursor_upd_t;

  // Advance the cursor for one character and decide on scroll or pause
  function automatic cursor_upd_t put_advance(logic [COL_W-1:0] col, logic [ROW_W-1:0] row,
                                              logic [TALLY_W-1:0] tally, logic [7:0] code);
    cursor_upd_t      u;
    logic [COL_W:0]   c1;
    logic [ROW_W:0]   r1;
    logic [TALLY_W-1:0] t1;
    c1 = {1'b0, col} + 1'b1;
    r1 = {1'b0, row};
    if (code == CHAR_NEWLINE) begin
      r1 = r1 + 1'b1;
      c1 = '0;
    end else if (c1 >= LINE_BYTES) begin
      r1 = r1 + 1'b1;
      c1 = '0;
    end
    u.col    = c1[COL_W-1:0];
    u.row    = r1[ROW_W-1:0];
    u.tally  = tally;
    u.pause  = 1'b0;
    u.scroll = 1'b0;
    if (r1 >= TEXT_ROWS) begin
      t1 = tally + 1'b1;
      u.tally = t1;
      if (t1 >= PAUSE_EVERY) begin
        u.row   = ROW_W'(TEXT_ROWS);
        u.pause = 1'b1;
      end else begin
        u.row    = ROW_W'(TEXT_ROWS - 1);
        u.scroll = 1'b1;
      end
    end
    return u;
  endfunction

  // Frame address of the top pixel line of a text cell
  function automatic logic [FRAME_AW-1:0] cell_base(logic [ROW_W-1:0] row,
                                                    logic [COL_W-1:0] col);
    return FRAME_AW'(row * CELL_SHIFT) + FRAME_AW'(col);
  endfunction

  // Glyph store index of the first byte of a character
  function automatic logic [GLYPH_AW-1:0] glyph_base(logic [7:0] code);
    logic [7:0] rel;
    rel = code - CHAR_FIRST;
    return GLYPH_AW'({rel, 3'b000});
  endfunction

endpackage

// ===== sv/tcbw_ram.sv =====
// Generic single-clock RAM: one write port and one registered read port.
// No dependencies.
module tcbw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/tcbw_seq.sv =====
// Sequencer of the text console writer: cursor state and the read/modify/write
// passes over the frame and glyph memories. Depends on tcbw_pkg.
module tcbw_seq (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  tcbw_pkg::in_item_t    in_data,
  output logic                  res_valid,
  input  logic                  res_take,
  output tcbw_pkg::out_item_t   res,
  output tcbw_pkg::frame_port_t frame_port,
  input  logic [7:0]            frame_rdata,
  output tcbw_pkg::glyph_port_t glyph_port,
  input  logic [7:0]            glyph_rdata
);
  import tcbw_pkg::*;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_DRAW   = 3'd2;
  localparam logic [2:0] S_FLUSH  = 3'd3;
  localparam logic [2:0] S_SCROLL = 3'd4;
  localparam logic [2:0] S_RDWAIT = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0]          state;
  logic [FRAME_AW-1:0] sweep;
  logic [STEP_W-1:0]   step;
  logic [COL_W-1:0]    col;
  logic [ROW_W-1:0]    row;
  logic [TALLY_W-1:0]  tally;
  logic                wait_q;
  logic                scroll_pend;
  logic [GLYPH_AW-1:0] glyph_addr;
  logic [FRAME_AW-1:0] draw_addr;
  logic                wpend;
  logic                wpend_glyph;
  logic [FRAME_AW-1:0] wpend_addr;
  logic [7:0]          rd_q;
  logic                rej_q;
  logic                accept;
  logic                drawn;
  cursor_upd_t         upd;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign res_valid = (state == S_DONE);
  assign drawn     = (in_data.char_code >= CHAR_FIRST);
  assign upd       = put_advance(col, row, tally, in_data.char_code);

  // Result fields straight from the state registers
  always_comb begin
    res.read_data  = rd_q;
    res.cursor_col = col;
    res.cursor_row = row;
    res.paused     = wait_q;
    res.rejected   = rej_q;
  end

  // Frame memory: clearing sweep, delayed write-back, reads for items and scroll
  always_comb begin
    frame_port.we    = 1'b0;
    frame_port.waddr = wpend_addr;
    frame_port.wdata = wpend_glyph ? glyph_rdata : frame_rdata;
    frame_port.re    = 1'b0;
    frame_port.raddr = in_data.address;
    if (state == S_CLEAR) begin
      frame_port.we    = 1'b1;
      frame_port.waddr = sweep;
      frame_port.wdata = '0;
    end else if (wpend) begin
      frame_port.we = 1'b1;
    end
    if (state == S_SCROLL) begin
      frame_port.re    = 1'b1;
      frame_port.raddr = sweep + FRAME_AW'(CELL_SHIFT);
    end else if (accept && in_data.req_type == REQ_READ && in_data.address < FRAME_BYTES) begin
      frame_port.re = 1'b1;
    end
  end

  // Glyph memory: writes from items, reads while drawing
  always_comb begin
    glyph_port.we    = accept && in_data.req_type == REQ_GLYPH &&
                       in_data.address < GLYPH_BYTES;
    glyph_port.waddr = in_data.address[GLYPH_AW-1:0];
    glyph_port.wdata = in_data.write_data;
    glyph_port.re    = (state == S_DRAW);
    glyph_port.raddr = glyph_addr;
  end

  // Sequence one item at a time
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      sweep       <= '0;
      col         <= '0;
      row         <= '0;
      tally       <= TALLY_W'(TALLY_RESET);
      wait_q      <= 1'b0;
      scroll_pend <= 1'b0;
      wpend       <= 1'b0;
    end else begin
      wpend <= 1'b0;
      case (state)
        S_CLEAR: begin
          if (sweep == FRAME_AW'(FRAME_BYTES - 1)) begin
            sweep <= '0;
            state <= S_IDLE;
          end else begin
            sweep <= sweep + 1'b1;
          end
        end
        S_IDLE: begin
          if (accept) begin
            rd_q  <= '0;
            rej_q <= 1'b0;
            case (in_data.req_type)
              REQ_PUT: begin
                if (wait_q) begin
                  rej_q <= 1'b1;
                  state <= S_DONE;
                end else begin
                  col         <= upd.col;
                  row         <= upd.row;
                  tally       <= upd.tally;
                  wait_q      <= upd.pause;
                  scroll_pend <= upd.scroll && drawn;
                  glyph_addr  <= glyph_base(in_data.char_code);
                  draw_addr   <= cell_base(row, col);
                  step        <= '0;
                  if (drawn) begin
                    state <= S_DRAW;
                  end else if (upd.scroll) begin
                    state <= S_SCROLL;
                  end else begin
                    state <= S_DONE;
                  end
                end
              end
              REQ_READ: begin
                state <= (in_data.address < FRAME_BYTES) ? S_RDWAIT : S_DONE;
              end
              REQ_CLICK: begin
                if (wait_q) begin
                  tally  <= '0;
                  row    <= ROW_W'(TEXT_ROWS - 1);
                  wait_q <= 1'b0;
                  state  <= S_SCROLL;
                end else begin
                  state <= S_DONE;
                end
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_DRAW: begin
          // Read one glyph byte; write it to the cell on the next cycle
          wpend       <= 1'b1;
          wpend_glyph <= 1'b1;
          wpend_addr  <= draw_addr;
          draw_addr   <= draw_addr + FRAME_AW'(LINE_BYTES);
          glyph_addr  <= glyph_addr + 1'b1;
          step        <= step + 1'b1;
          if (step == STEP_W'(GLYPH_LINES - 1)) begin
            state <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          if (scroll_pend) begin
            scroll_pend <= 1'b0;
            state       <= S_SCROLL;
          end else begin
            state <= S_DONE;
          end
        end
        S_SCROLL: begin
          // Read one row of text ahead; write the byte back on the next cycle
          wpend       <= 1'b1;
          wpend_glyph <= 1'b0;
          wpend_addr  <= sweep;
          if (sweep == FRAME_AW'(SCROLL_COUNT - 1)) begin
            sweep <= '0;
            state <= S_FLUSH;
          end else begin
            sweep <= sweep + 1'b1;
          end
        end
        S_RDWAIT: begin
          rd_q  <= frame_rdata;
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sv/text_console_bitplane_writer.sv =====
// Top level of the text console bitplane writer: memories, sequencer, result register.
// Depends on tcbw_pkg, tcbw_ram, tcbw_seq and text_console_bitplane_writer_defines.svh.
//
// Renders 8x8 glyphs into a 640-pixel-wide one-bit framebuffer held in a
// 16640-byte RAM, with an 80x25 text cursor. One item is in work at a time.
// After reset the frame RAM is cleared by a sweep over every byte, during which
// in_ready stays low. A drawn character makes eight glyph-RAM reads, each
// written to the frame RAM in the following cycle, before its result can be
// taken; a read waits on one frame-RAM read. A scroll copies 16000 bytes
// through the frame RAM's read and write ports at one byte a cycle. A finished
// result sits in an output register, so the next item is taken while it waits.
`include "text_console_bitplane_writer_defines.svh"

module text_console_bitplane_writer (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  tcbw_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output tcbw_pkg::out_item_t out_data
);
  import tcbw_pkg::*;

  frame_port_t frame_port;
  glyph_port_t glyph_port;
  logic [7:0]  frame_rdata;
  logic [7:0]  glyph_rdata;
  logic        res_valid;
  logic        res_take;
  out_item_t   res;

  tcbw_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_frame_ram (
    .clk   (clk),
    .we    (frame_port.we),
    .waddr (frame_port.waddr),
    .wdata (frame_port.wdata),
    .re    (frame_port.re),
    .raddr (frame_port.raddr),
    .rdata (frame_rdata)
  );

  tcbw_ram #(.WIDTH(8), .DEPTH(GLYPH_BYTES)) u_glyph_ram (
    .clk   (clk),
    .we    (glyph_port.we),
    .waddr (glyph_port.waddr),
    .wdata (glyph_port.wdata),
    .re    (glyph_port.re),
    .raddr (glyph_port.raddr),
    .rdata (glyph_rdata)
  );

  tcbw_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .res_valid   (res_valid),
    .res_take    (res_take),
    .res         (res),
    .frame_port  (frame_port),
    .frame_rdata (frame_rdata),
    .glyph_port  (glyph_port),
    .glyph_rdata (glyph_rdata)
  );

  // Load the result register when it is empty or being drained
  assign res_take = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      out_data <= res;
    end
  end

  `TCBW_ASSERT_NEXT(a_one_item_in_work, in_valid && in_ready, !in_ready, "item taken while busy")
  `TCBW_ASSERT_SAME(a_reject_only_paused, out_valid && out_data.rejected, out_data.paused, "reject while not paused")
  `TCBW_ASSERT_SAME(a_row_in_grid, out_valid && !out_data.paused, out_data.cursor_row < TEXT_ROWS, "row past grid")
  `TCBW_ASSERT_SAME(a_col_in_grid, out_valid, out_data.cursor_col < LINE_BYTES, "column past grid")

endmodule

// ===== bench/text_console_bitplane_writer_test.sv =====
// Self-checking bench for text_console_bitplane_writer: glyph drawing, cursor, scroll and pause.
// Depends on tcbw_pkg and the block's RTL; keeps its own copy of the frame and glyph stores.
`timescale 1ns / 1ps

module text_console_bitplane_writer_test;
  import tcbw_pkg::*;

  localparam int ITEM_TARGET    = 600;
  localparam int SCROLL_BUDGET  = 30;
  localparam int CALM_TAIL      = 60;
  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 100000;

  // Text cursor with scroll bookkeeping; scroll marks a copy done by this item
  typedef struct packed {
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
    logic [TALLY_W-1:0] tally;
    logic               waiting;
    logic               scroll;
  } console_cursor_t;

  typedef struct {
    in_item_t item;
    bit       hold_for_drain;
  } request_slot_t;

  localparam console_cursor_t CURSOR_AT_RESET = '{col: '0, row: '0,
                                                  tally: TALLY_W'(TALLY_RESET),
                                                  waiting: 1'b0, scroll: 1'b0};

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  text_console_bitplane_writer u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #6 clk = ~clk;

  // Shadow of the block, advanced on every accepted item
  logic [7:0]      frame_mem [FRAME_BYTES] = '{default: '0};
  logic [7:0]      glyph_mem [GLYPH_BYTES] = '{default: '0};
  console_cursor_t screen = CURSOR_AT_RESET;
  out_item_t       console_replies_due[$];

  // Stimulus planning state, advanced as items are queued
  request_slot_t   console_requests[$];
  console_cursor_t plan_cursor = CURSOR_AT_RESET;
  bit              glyph_loaded [GLYPH_BYTES];
  logic [7:0]      loaded_codes[$];
  bit              hold_next = 1'b0;
  int              planned_items = 0;
  int              plan_scrolls = 0;

  int error_count = 0;
  int requests_taken = 0;
  int results_checked = 0;
  int glyphs_drawn = 0;
  int scrolls_seen = 0;
  int pauses_seen = 0;
  int rejects_seen = 0;

  logic calm_tail = 1'b0;
  int   send_gap = 0;
  int   recv_gap = 0;
  int   calm_left = 0;
  int   idle_cycles = 0;

  // Advance the cursor by one character; overflow past the last row scrolls or pauses
  function automatic console_cursor_t cursor_after_put(console_cursor_t c, logic [7:0] code);
    console_cursor_t n;
    int col;
    int row;
    n = c;
    n.scroll = 1'b0;
    if (c.waiting) return n;
    col = int'(c.col) + 1;
    row = int'(c.row);
    if (code == CHAR_NEWLINE || col >= LINE_BYTES) begin
      row++;
      col = 0;
    end
    if (row >= TEXT_ROWS) begin
      n.tally = c.tally + 1'b1;
      if (n.tally >= PAUSE_EVERY) begin
        row = TEXT_ROWS;
        n.waiting = 1'b1;
      end else begin
        row = TEXT_ROWS - 1;
        n.scroll = 1'b1;
      end
    end
    n.col = COL_W'(col);
    n.row = ROW_W'(row);
    return n;
  endfunction

  // A click releases a pending scroll and restarts the tally
  function automatic console_cursor_t cursor_after_click(console_cursor_t c);
    console_cursor_t n;
    n = c;
    n.scroll = 1'b0;
    if (c.waiting) begin
      n.tally = '0;
      n.row = ROW_W'(TEXT_ROWS - 1);
      n.waiting = 1'b0;
      n.scroll = 1'b1;
    end
    return n;
  endfunction

  // Apply one item to the shadow stores and form the reply it should produce
  task automatic render_console_item(in_item_t req, output out_item_t reply);
    console_cursor_t nxt;
    int glyph_at;
    int frame_at;
    reply = '0;
    nxt = screen;
    nxt.scroll = 1'b0;
    case (req.req_type)
      REQ_PUT: begin
        if (screen.waiting) begin
          reply.rejected = 1'b1;
          rejects_seen++;
        end else begin
          if (req.char_code >= CHAR_FIRST) begin
            for (int i = 0; i < GLYPH_LINES; i++) begin
              glyph_at = (int'(req.char_code) - int'(CHAR_FIRST)) * GLYPH_LINES + i;
              frame_at = LINE_BYTES * (int'(screen.row) * GLYPH_LINES + i) + int'(screen.col);
              if (frame_at < FRAME_BYTES)
                frame_mem[frame_at] = (glyph_at < GLYPH_BYTES) ? glyph_mem[glyph_at] : 8'h00;
            end
            glyphs_drawn++;
          end
          nxt = cursor_after_put(screen, req.char_code);
        end
      end
      REQ_READ: begin
        if (req.address < FRAME_BYTES) reply.read_data = frame_mem[req.address];
      end
      REQ_CLICK: begin
        nxt = cursor_after_click(screen);
      end
      REQ_GLYPH: begin
        if (req.address < GLYPH_BYTES) glyph_mem[req.address] = req.write_data;
      end
      default: ;
    endcase
    // Move every text row up one cell; the bottom lines stay blank
    if (nxt.scroll) begin
      for (int k = 0; k < SCROLL_COUNT; k++) frame_mem[k] = frame_mem[k + CELL_SHIFT];
      scrolls_seen++;
    end
    if (nxt.waiting && !screen.waiting) pauses_seen++;
    screen = nxt;
    reply.cursor_col = screen.col;
    reply.cursor_row = screen.row;
    reply.paused = screen.waiting;
  endtask

  // Queue one item and track what it will do to the planned cursor
  task automatic queue_request(logic [1:0] req, logic [7:0] code, logic [14:0] addr,
                               logic [7:0] data);
    request_slot_t   slot;
    console_cursor_t nxt;
    bit              effective;
    slot.item.req_type = req;
    slot.item.char_code = code;
    slot.item.address = addr;
    slot.item.write_data = data;
    slot.hold_for_drain = hold_next;
    hold_next = 1'b0;
    console_requests.push_back(slot);
    effective = 1'b1;
    case (req)
      REQ_PUT: begin
        if (plan_cursor.waiting) begin
          effective = 1'b0;
        end else begin
          nxt = cursor_after_put(plan_cursor, code);
          if (nxt.scroll) plan_scrolls++;
          plan_cursor = nxt;
        end
      end
      REQ_CLICK: begin
        if (!plan_cursor.waiting) begin
          effective = 1'b0;
        end else begin
          plan_cursor = cursor_after_click(plan_cursor);
          plan_scrolls++;
        end
      end
      REQ_GLYPH: begin
        if (addr < GLYPH_BYTES) glyph_loaded[addr] = 1'b1;
        else effective = 1'b0;
      end
      default: ;
    endcase
    if (effective) planned_items++;
  endtask

  // Read a byte, half of the time from the cell just drawn
  task automatic queue_read();
    int pick;
    int row;
    int col;
    int addr;
    pick = $urandom_range(0, 99);
    row = (plan_cursor.row >= TEXT_ROWS) ? TEXT_ROWS - 1 : int'(plan_cursor.row);
    col = (plan_cursor.col == 0) ? 0 : int'(plan_cursor.col) - 1;
    if (pick < 50) addr = row * CELL_SHIFT + $urandom_range(0, 7) * LINE_BYTES + col;
    else if (pick < 85) addr = $urandom_range(0, FRAME_BYTES - 1);
    else addr = $urandom_range(FRAME_BYTES, 32767);
    queue_request(REQ_READ, 8'($urandom), 15'(addr), 8'($urandom));
  endtask

  // Put a character, loading its glyph first if any byte of it is still unwritten
  task automatic queue_put(logic [7:0] code);
    console_cursor_t nxt;
    int base;
    bit fresh;
    if (code >= CHAR_FIRST) begin
      base = (int'(code) - int'(CHAR_FIRST)) * GLYPH_LINES;
      fresh = 1'b0;
      for (int i = 0; i < GLYPH_LINES; i++) begin
        if (!glyph_loaded[base + i]) begin
          queue_request(REQ_GLYPH, 8'($urandom), 15'(base + i), 8'($urandom));
          fresh = 1'b1;
        end
      end
      if (fresh) loaded_codes.push_back(code);
    end
    // Keep the number of full-screen copies bounded
    nxt = cursor_after_put(plan_cursor, code);
    if (nxt.scroll && plan_scrolls >= SCROLL_BUDGET) queue_read();
    else queue_request(REQ_PUT, code, 15'($urandom), 8'($urandom));
  endtask

  function automatic logic [7:0] pick_char_code();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return CHAR_NEWLINE;
    if (r < 40) return 8'($urandom_range(0, 31));
    if (r < 50 || loaded_codes.size() == 0) return 8'($urandom_range(32, 255));
    return loaded_codes[$urandom_range(0, loaded_codes.size() - 1)];
  endfunction

  task automatic report_field(string field, logic [7:0] want, logic [7:0] got);
    $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    error_count++;
  endtask

  // Drive requests from the queue, with random gaps and an occasional drain
  always @(posedge clk) begin
    logic took;
    logic go;
    if (rst) begin
      in_valid <= 1'b0;
      in_data <= '0;
      send_gap = 0;
    end else begin
      took = in_valid && in_ready;
      calm_tail <= (console_requests.size() < CALM_TAIL);
      if (!in_valid || took) begin
        if (send_gap > 0) begin
          send_gap--;
          go = 1'b0;
        end else if (console_requests.size() == 0) begin
          go = 1'b0;
        end else if (console_requests[0].hold_for_drain &&
                     (took || console_replies_due.size() != 0)) begin
          go = 1'b0;
        end else begin
          go = 1'b1;
        end
        if (go) begin
          in_data <= console_requests[0].item;
          console_requests.pop_front();
          if (!calm_tail && $urandom_range(0, 4) == 0) send_gap = $urandom_range(1, 14);
        end
        in_valid <= go;
      end
    end
  end

  // Predict on input accept, check on output accept, and throttle out_ready
  always @(posedge clk) begin
    out_item_t want;
    logic      take;
    if (rst) begin
      out_ready <= 1'b0;
      recv_gap = 0;
      calm_left = 0;
    end else begin
      if (in_valid && in_ready === 1'b1) begin
        render_console_item(in_data, want);
        console_replies_due.push_back(want);
        requests_taken++;
      end
      if (out_valid === 1'b1 && out_ready) begin
        if (console_replies_due.size() == 0) begin
          $display("%0t ns: result with none expected, got %h", $time, out_data);
          error_count++;
        end else begin
          want = console_replies_due.pop_front();
          if (out_data.read_data !== want.read_data)
            report_field("read_data", want.read_data, out_data.read_data);
          if (out_data.cursor_col !== want.cursor_col)
            report_field("cursor_col", 8'(want.cursor_col), 8'(out_data.cursor_col));
          if (out_data.cursor_row !== want.cursor_row)
            report_field("cursor_row", 8'(want.cursor_row), 8'(out_data.cursor_row));
          if (out_data.paused !== want.paused)
            report_field("paused", 8'(want.paused), 8'(out_data.paused));
          if (out_data.rejected !== want.rejected)
            report_field("rejected", 8'(want.rejected), 8'(out_data.rejected));
          results_checked++;
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        take = 1'b0;
      end else if (calm_left > 0 || calm_tail) begin
        if (calm_left > 0) calm_left--;
        take = 1'b1;
      end else if ($urandom_range(0, 7) == 0) begin
        recv_gap = $urandom_range(0, 13);
        take = 1'b0;
      end else begin
        take = 1'b1;
        if ($urandom_range(0, 63) == 0) calm_left = $urandom_range(50, 400);
      end
      out_ready <= take;
    end
  end

  // End the run if neither side moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("%0t ns: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("text_console_bitplane_writer_test: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [7:0] corner_glyph [GLYPH_LINES] = '{8'hFF, 8'h00, 8'hAA, 8'h55,
                                               8'h80, 8'h01, 8'h7F, 8'hFE};
    int pick;
    logic [7:0] code;

    // Directed: cleared frame, address limits, stray click, glyph index limits
    queue_request(REQ_READ, 8'h00, 15'd0, 8'h00);
    queue_request(REQ_READ, 8'hFF, 15'(FRAME_BYTES - 1), 8'hFF);
    queue_request(REQ_READ, 8'h00, 15'(FRAME_BYTES), 8'h00);
    queue_request(REQ_READ, 8'hFF, 15'h7FFF, 8'hFF);
    queue_request(REQ_CLICK, 8'hFF, 15'h7FFF, 8'hFF);
    queue_request(REQ_GLYPH, 8'h00, 15'(GLYPH_BYTES), 8'hFF);
    queue_request(REQ_GLYPH, 8'hFF, 15'h7FFF, 8'h5A);
    // Load the last glyph, draw it at the origin and read its top and bottom lines
    for (int i = 0; i < GLYPH_LINES; i++)
      queue_request(REQ_GLYPH, 8'h00, 15'(GLYPH_BYTES - GLYPH_LINES + i), corner_glyph[i]);
    loaded_codes.push_back(8'hFF);
    queue_put(8'hFF);
    queue_request(REQ_READ, 8'h00, 15'd0, 8'h00);
    queue_request(REQ_READ, 8'h00, 15'(7 * LINE_BYTES), 8'h00);
    // Undrawn control codes at both ends, then newline
    queue_put(8'h00);
    queue_put(8'h1F);
    queue_put(CHAR_NEWLINE);

    // Random: text runs with reads, glyph updates, clicks and drains
    hold_next = 1'b1;
    while (planned_items < ITEM_TARGET) begin
      if ($urandom_range(0, 49) == 0) hold_next = 1'b1;
      pick = $urandom_range(0, 99);
      if (plan_cursor.waiting && plan_scrolls < SCROLL_BUDGET && pick < 30) begin
        queue_request(REQ_CLICK, 8'($urandom), 15'($urandom), 8'($urandom));
      end else if (pick < 1) begin
        // Fill to the end of the line to exercise the column wrap
        for (int n = 0; n < 90; n++) begin
          code = ($urandom_range(0, 99) < 15) ? 8'($urandom_range(11, 31)) :
                                                 8'($urandom_range(32, 255));
          queue_put(code);
          if (plan_cursor.col == 0 || plan_cursor.waiting) break;
        end
      end else if (pick < 58) begin
        queue_put(pick_char_code());
      end else if (pick < 80) begin
        queue_read();
      end else if (pick < 93) begin
        if ($urandom_range(0, 99) < 85)
          queue_request(REQ_GLYPH, 8'($urandom), 15'($urandom_range(0, GLYPH_BYTES - 1)),
                        8'($urandom));
        else
          queue_request(REQ_GLYPH, 8'($urandom), 15'($urandom_range(GLYPH_BYTES, 32767)),
                        8'($urandom));
      end else if (plan_cursor.waiting && plan_scrolls >= SCROLL_BUDGET) begin
        queue_read();
      end else begin
        queue_request(REQ_CLICK, 8'($urandom), 15'($urandom), 8'($urandom));
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Wait for every request to go in and every reply to come back
    do @(negedge clk);
    while (console_requests.size() != 0 || in_valid || console_replies_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Checked %0d replies to %0d requests: %0d glyphs drawn, %0d scrolls,",
             results_checked, requests_taken, glyphs_drawn, scrolls_seen);
    $display("%0d pauses for a click, %0d puts turned away while paused, %0d mismatches.",
             pauses_seen, rejects_seen, error_count);
    if (error_count == 0) begin
      $display("text_console_bitplane_writer_test: PASS");
    end else begin
      $display("text_console_bitplane_writer_test: FAIL");
    end
    $finish;
  end

endmodule
